@@ rtl/core/lh_pkg.sv @@
// shared constants, types and helpers for the latency histogram
package lh_pkg;

    localparam int MAX_BINS     = 64;
    localparam int DEFAULT_BINS = 16;
    localparam int COUNT_WIDTH  = 32;

    localparam int NS_PER_US = 1000;

    localparam int RANGE_W   = 40;
    localparam int BCOUNT_W  = 7;
    localparam int LIMIT_W   = 32;
    localparam int TS_W      = 48;
    localparam int SEL_W     = 6;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    localparam int BINS_W = $clog2(MAX_BINS + 1);
    localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam t_mode MODE_SEND = 2'd0;
    localparam t_mode MODE_RECV = 2'd1;
    localparam t_mode MODE_READ = 2'd2;
    localparam t_mode MODE_NOP  = 2'd3;

    localparam t_cfg_idx CFG_RANGE_BEGIN  = 2'd0;
    localparam t_cfg_idx CFG_RANGE_END    = 2'd1;
    localparam t_cfg_idx CFG_BIN_COUNT    = 2'd2;
    localparam t_cfg_idx CFG_REPEAT_LIMIT = 2'd3;

    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == '1) ? v : v + COUNT_WIDTH'(1);
        return r;
    endfunction

endpackage

@@ rtl/core/latency_histogram.sv @@
// latency histogram top level: event sequencer, serial divider and bin memory
//
// Each transfer in is one event. A send or an idle code goes from the execute
// state to the output state and a bin read passes a read-wait state. A binned
// receive passes the multiply, divide, index and increment states; one whose bin
// falls outside the histogram skips the increment. The restoring divider that
// forms the bin number retires two quotient bits per cycle over a 56-bit
// dividend. A receive with a non-positive latency or an empty range goes straight
// to the output state. The input is ready again in the cycle after the result is
// loaded. The histogram sits in a single-port memory with a registered read and
// is updated by read, increment, write back; one event is handled at a time, so
// accesses never overlap. Per-bin valid bits cleared at reset make every bin
// read as zero until first written, so no clearing pass is needed and events are
// taken right after reset. The result sits in an output register, so the next
// event is accepted while it waits.
module latency_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lh_pkg::t_mode                 i_mode,
    input  logic [lh_pkg::TS_W-1:0]       i_timestamp,
    input  logic [lh_pkg::SEL_W-1:0]      i_bin_select,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [lh_pkg::OUT_W-1:0] o_bin_index,
    output logic                          o_in_range,
    output logic                          o_error,
    output logic [lh_pkg::OUT_W-1:0]      o_sent_total,
    output logic [lh_pkg::OUT_W-1:0]      o_received_total,
    output logic [lh_pkg::OUT_W-1:0]      o_lost_total,
    output logic [lh_pkg::OUT_W-1:0]      o_outside_total,
    output logic [lh_pkg::OUT_W-1:0]      o_binned_total,
    output logic [lh_pkg::OUT_W-2:0]      o_largest_bin,
    output logic                          o_stop,
    output logic [lh_pkg::OUT_W-1:0]      o_selected_count,
    input  logic                          i_cfg_we,
    input  lh_pkg::t_cfg_idx              i_cfg_index,
    input  logic [lh_pkg::CFG_W-1:0]      i_cfg_data
);
    import lh_pkg::*;

    localparam int PROD_W    = TS_W + BINS_W;
    localparam int DIV_W     = PROD_W + (PROD_W % 2);
    localparam int DEN_W     = RANGE_W + $clog2(NS_PER_US);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [DIV_W-1:0] Q_POS_MAX = DIV_W'(64'h7FFF_FFFF);
    localparam logic [DIV_W-1:0] Q_NEG_MAX = DIV_W'(64'h8000_0000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_IDX,
        S_INC,
        S_RDW,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [RANGE_W-1:0]  r_range_begin;
    logic [RANGE_W-1:0]  r_range_end;
    logic [BCOUNT_W-1:0] r_bin_count;
    logic [LIMIT_W-1:0]  r_repeat_limit;

    // block state
    logic [TS_W-1:0]  r_send_time;
    t_count           r_sent;
    t_count           r_recv;
    t_count           r_outside;
    t_count           r_binned;
    logic [OUT_W-2:0] r_largest;
    logic             r_hist_vld [MAX_BINS];

    // current event
    t_mode             r_mode;
    logic [TS_W-1:0]   r_ts;
    logic [SEL_W-1:0]  r_sel;
    logic              r_neg;
    logic [TS_W-1:0]   r_mag;
    logic [RANGE_W-1:0] r_span;
    logic [BINS_W-1:0] r_bins;
    logic [DIV_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [BIN_AW-1:0] r_addr;

    logic signed [OUT_W-1:0] r_bin_index;
    logic                    r_in_range;
    logic                    r_error;
    t_count                  r_sel_count;

    // result register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_o_bin_index;
    logic                    r_o_in_range;
    logic                    r_o_error;
    logic [OUT_W-1:0]        r_o_sent;
    logic [OUT_W-1:0]        r_o_recv;
    logic [OUT_W-1:0]        r_o_lost;
    logic [OUT_W-1:0]        r_o_outside;
    logic [OUT_W-1:0]        r_o_binned;
    logic [OUT_W-2:0]        r_o_largest;
    logic                    r_o_stop;
    logic [OUT_W-1:0]        r_o_sel_count;

    // histogram memory
    t_count            r_hist [MAX_BINS];
    t_count            r_hist_q;
    logic              mem_re;
    logic [BIN_AW-1:0] mem_raddr;
    logic              mem_we;
    t_count            mem_wdata;

    // receive preparation
    logic signed [TS_W:0] elapsed;
    logic                 elapsed_pos;
    logic [TS_W:0]        diff;
    logic [RANGE_W-1:0]   span;
    logic [BINS_W-1:0]    eff_bins;
    logic                 sel_ok;

    // divider step
    logic [DIV_W-1:0] n_num;
    logic [DEN_W-1:0] n_rem;

    // bin evaluation
    logic                    q_nonneg;
    logic signed [OUT_W-1:0] idx_sat;
    logic [OUT_W-2:0]        idx_u;
    logic                    idx_in;
    t_count                  hist_cur;

    logic out_load;

    always_comb begin
        int b;
        elapsed     = signed'({1'b0, r_ts}) - signed'({1'b0, r_send_time});
        elapsed_pos = !elapsed[TS_W] && (elapsed != '0);
        diff        = {1'b0, elapsed[TS_W-1:0]} - (TS_W + 1)'(r_range_begin);
        if (r_range_end < r_range_begin) begin
            span = RANGE_W'(DEFAULT_BINS);
        end else begin
            span = r_range_end - r_range_begin;
        end
        b = (r_bin_count == '0) ? DEFAULT_BINS : int'(r_bin_count);
        if (b > MAX_BINS) begin
            b = MAX_BINS;
        end
        eff_bins = BINS_W'(b);
        sel_ok   = int'(r_sel) < MAX_BINS;
    end

    always_comb begin
        logic [DEN_W:0]   shifted;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] rem;
        num = r_num;
        rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            shifted = {rem, num[DIV_W-1]};
            if (shifted >= {1'b0, r_den}) begin
                shifted = shifted - {1'b0, r_den};
                num     = {num[DIV_W-2:0], 1'b1};
            end else begin
                num     = {num[DIV_W-2:0], 1'b0};
            end
            rem = shifted[DEN_W-1:0];
        end
        n_num = num;
        n_rem = rem;
    end

    always_comb begin
        q_nonneg = !r_neg || (r_num == '0);
        if (q_nonneg) begin
            idx_sat = (r_num > Q_POS_MAX) ? 32'sh7FFF_FFFF : signed'(r_num[OUT_W-1:0]);
        end else if (r_num > Q_NEG_MAX) begin
            idx_sat = 32'sh8000_0000;
        end else begin
            idx_sat = signed'(OUT_W'(0) - r_num[OUT_W-1:0]);
        end
        idx_u    = (r_num > Q_POS_MAX) ? '1 : r_num[OUT_W-2:0];
        idx_in   = q_nonneg && (r_num < DIV_W'(r_bins));
        hist_cur = r_hist_vld[r_addr] ? r_hist_q : '0;
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = BIN_AW'(r_sel);
        if (r_state == S_EXEC && r_mode == MODE_READ && sel_ok) begin
            mem_re = 1'b1;
        end else if (r_state == S_IDX && idx_in) begin
            mem_re    = 1'b1;
            mem_raddr = r_num[BIN_AW-1:0];
        end
        mem_we    = (r_state == S_INC);
        mem_wdata = sat_inc(hist_cur);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_hist_q <= r_hist[mem_raddr];
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_range_begin  <= '0;
            r_range_end    <= RANGE_W'(16);
            r_bin_count    <= BCOUNT_W'(16);
            r_repeat_limit <= LIMIT_W'(1000);
            r_send_time    <= '0;
            r_sent         <= '0;
            r_recv         <= '0;
            r_outside      <= '0;
            r_binned       <= '0;
            r_largest      <= '0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < MAX_BINS; k++) begin
                r_hist_vld[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RANGE_BEGIN:  r_range_begin  <= i_cfg_data[RANGE_W-1:0];
                    CFG_RANGE_END:    r_range_end    <= i_cfg_data[RANGE_W-1:0];
                    CFG_BIN_COUNT:    r_bin_count    <= i_cfg_data[BCOUNT_W-1:0];
                    CFG_REPEAT_LIMIT: r_repeat_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode      <= i_mode;
                        r_ts        <= i_timestamp;
                        r_sel       <= i_bin_select;
                        r_bin_index <= '0;
                        r_in_range  <= 1'b0;
                        r_error     <= 1'b0;
                        r_sel_count <= '0;
                        r_state     <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_mode)
                        MODE_SEND: begin
                            r_send_time <= r_ts;
                            r_sent      <= sat_inc(r_sent);
                            r_state     <= S_OUT;
                        end
                        MODE_RECV: begin
                            r_recv <= sat_inc(r_recv);
                            if (!elapsed_pos) begin
                                r_error <= 1'b1;
                                r_state <= S_OUT;
                            end else if (span == '0) begin
                                r_outside <= sat_inc(r_outside);
                                r_state   <= S_OUT;
                            end else begin
                                r_neg   <= diff[TS_W];
                                r_mag   <= diff[TS_W] ? TS_W'(~diff + 1'b1) : diff[TS_W-1:0];
                                r_span  <= span;
                                r_bins  <= eff_bins;
                                r_state <= S_MUL;
                            end
                        end
                        MODE_READ: begin
                            r_state <= sel_ok ? S_RDW : S_OUT;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_MUL: begin
                    r_num   <= DIV_W'(r_mag) * DIV_W'(r_bins);
                    r_den   <= DEN_W'(r_span) * DEN_W'(NS_PER_US);
                    r_rem   <= '0;
                    r_step  <= STEP_W'(DIV_STEPS);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num  <= n_num;
                    r_rem  <= n_rem;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == STEP_W'(1)) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_bin_index <= idx_sat;
                    if (q_nonneg && idx_u > r_largest) begin
                        r_largest <= idx_u;
                    end
                    if (idx_in) begin
                        r_addr  <= r_num[BIN_AW-1:0];
                        r_state <= S_INC;
                    end else begin
                        r_outside <= sat_inc(r_outside);
                        r_state   <= S_OUT;
                    end
                end
                S_INC: begin
                    r_hist_vld[r_addr] <= 1'b1;
                    r_binned           <= sat_inc(r_binned);
                    r_in_range         <= 1'b1;
                    r_state            <= S_OUT;
                end
                S_RDW: begin
                    r_sel_count <= r_hist_vld[BIN_AW'(r_sel)] ? r_hist_q : '0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_bin_index <= r_bin_index;
            r_o_in_range  <= r_in_range;
            r_o_error     <= r_error;
            r_o_sent      <= OUT_W'(r_sent);
            r_o_recv      <= OUT_W'(r_recv);
            r_o_lost      <= OUT_W'(r_sent - r_recv);
            r_o_outside   <= OUT_W'(r_outside);
            r_o_binned    <= OUT_W'(r_binned);
            r_o_largest   <= r_largest;
            r_o_stop      <= 64'(r_sent) >= 64'(r_repeat_limit);
            r_o_sel_count <= OUT_W'(r_sel_count);
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_bin_index      = r_o_bin_index;
    assign o_in_range       = r_o_in_range;
    assign o_error          = r_o_error;
    assign o_sent_total     = r_o_sent;
    assign o_received_total = r_o_recv;
    assign o_lost_total     = r_o_lost;
    assign o_outside_total  = r_o_outside;
    assign o_binned_total   = r_o_binned;
    assign o_largest_bin    = r_o_largest;
    assign o_stop           = r_o_stop;
    assign o_selected_count = r_o_sel_count;

endmodule

@@ rtl/core/lh_check.sv @@
// port-level checker for the latency histogram, bound to the top level
module lh_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic signed [lh_pkg::OUT_W-1:0] o_bin_index,
    input logic                            o_in_range,
    input logic                            o_error,
    input logic [lh_pkg::OUT_W-1:0]        o_sent_total,
    input logic [lh_pkg::OUT_W-2:0]        o_largest_bin
);
    import lh_pkg::*;

    // held result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_index)
            && $stable(o_sent_total))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_error_not_binned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> !o_in_range && (o_bin_index == '0))
        else $error("failed receive was binned");

    a_binned_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_range |-> !o_bin_index[OUT_W-1]
            && (o_largest_bin >= o_bin_index[OUT_W-2:0]))
        else $error("binned index negative or above largest");

endmodule

bind latency_histogram lh_check u_lh_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_bin_index   (o_bin_index),
    .o_in_range    (o_in_range),
    .o_error       (o_error),
    .o_sent_total  (o_sent_total),
    .o_largest_bin (o_largest_bin)
);

@@ dv/latency_histogram_checker.sv @@
// latency histogram checker: watches both channels and the register port, predicts and compares
module latency_histogram_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  lh_pkg::t_mode                   i_mode,
    input  logic [lh_pkg::TS_W-1:0]         i_timestamp,
    input  logic [lh_pkg::SEL_W-1:0]        i_bin_select,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [lh_pkg::OUT_W-1:0] i_bin_index,
    input  logic                            i_in_range,
    input  logic                            i_error,
    input  logic [lh_pkg::OUT_W-1:0]        i_sent_total,
    input  logic [lh_pkg::OUT_W-1:0]        i_received_total,
    input  logic [lh_pkg::OUT_W-1:0]        i_lost_total,
    input  logic [lh_pkg::OUT_W-1:0]        i_outside_total,
    input  logic [lh_pkg::OUT_W-1:0]        i_binned_total,
    input  logic [lh_pkg::OUT_W-2:0]        i_largest_bin,
    input  logic                            i_stop,
    input  logic [lh_pkg::OUT_W-1:0]        i_selected_count,
    input  logic                            i_cfg_we,
    input  lh_pkg::t_cfg_idx                i_cfg_index,
    input  logic [lh_pkg::CFG_W-1:0]        i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lh_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] bin_index;
        logic                    in_range;
        logic                    error;
        logic [OUT_W-1:0]        sent_total;
        logic [OUT_W-1:0]        received_total;
        logic [OUT_W-1:0]        lost_total;
        logic [OUT_W-1:0]        outside_total;
        logic [OUT_W-1:0]        binned_total;
        logic [OUT_W-2:0]        largest_bin;
        logic                    stop;
        logic [OUT_W-1:0]        selected_count;
    } t_hist_result;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    logic [RANGE_W-1:0]  range_lo;
    logic [RANGE_W-1:0]  range_hi;
    logic [BCOUNT_W-1:0] bins_reg;
    logic [LIMIT_W-1:0]  stop_limit;

    t_count           hist [MAX_BINS];
    logic [TS_W-1:0]  last_send;
    t_count           sent_cnt;
    t_count           recv_cnt;
    t_count           outside_cnt;
    t_count           binned_cnt;
    logic [OUT_W-2:0] peak_bin;

    t_hist_result awaited_q [$];

    function automatic t_count saturating_bump(t_count v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_hist_result tally_event(t_mode m, logic [TS_W-1:0] ts,
                                                 logic [SEL_W-1:0] sel);
        t_hist_result       r;
        longint             elapsed;
        longint             span;
        longint             idx;
        int                 nbins;
        logic [RANGE_W:0]   hi_edge;
        logic [OUT_W-2:0]   clipped;
        r = '0;
        case (m)
            MODE_SEND: begin
                last_send = ts;
                sent_cnt = saturating_bump(sent_cnt);
            end
            MODE_RECV: begin
                elapsed = $signed({16'd0, ts}) - $signed({16'd0, last_send});
                recv_cnt = saturating_bump(recv_cnt);
                if (elapsed <= 0) begin
                    r.error = 1'b1;
                end else begin
                    nbins = (bins_reg == 0) ? DEFAULT_BINS :
                            (int'(bins_reg) > MAX_BINS) ? MAX_BINS : int'(bins_reg);
                    hi_edge = (range_hi < range_lo) ? {1'b0, range_lo} + DEFAULT_BINS
                                                    : {1'b0, range_hi};
                    if (hi_edge == {1'b0, range_lo}) begin
                        outside_cnt = saturating_bump(outside_cnt);
                    end else begin
                        span = $signed({23'd0, hi_edge}) - $signed({24'd0, range_lo});
                        idx = (elapsed - $signed({24'd0, range_lo})) * longint'(nbins);
                        idx = idx / span;
                        idx = idx / longint'(NS_PER_US);
                        if (idx >= 0) begin
                            clipped = (idx > I32_MAX) ? '1 : idx[OUT_W-2:0];
                            if (clipped > peak_bin) peak_bin = clipped;
                        end
                        if (idx >= 0 && idx < longint'(nbins)) begin
                            hist[idx[BIN_AW-1:0]] = saturating_bump(hist[idx[BIN_AW-1:0]]);
                            binned_cnt = saturating_bump(binned_cnt);
                            r.in_range = 1'b1;
                        end else begin
                            outside_cnt = saturating_bump(outside_cnt);
                        end
                        r.bin_index = (idx > I32_MAX) ? I32_MAX[OUT_W-1:0] :
                                      (idx < I32_MIN) ? I32_MIN[OUT_W-1:0] : idx[OUT_W-1:0];
                    end
                end
            end
            MODE_READ: r.selected_count = hist[sel];
            default: ;
        endcase
        r.sent_total     = sent_cnt;
        r.received_total = recv_cnt;
        r.lost_total     = sent_cnt - recv_cnt;
        r.outside_total  = outside_cnt;
        r.binned_total   = binned_cnt;
        r.largest_bin    = peak_bin;
        r.stop           = (sent_cnt >= stop_limit);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : track
        t_hist_result got;
        t_hist_result want;
        int           moved;
        if (!i_rst_n) begin
            range_lo = '0;
            range_hi = RANGE_W'(16);
            bins_reg = BCOUNT_W'(16);
            stop_limit = LIMIT_W'(1000);
            foreach (hist[k]) hist[k] = '0;
            last_send = '0;
            sent_cnt = '0;
            recv_cnt = '0;
            outside_cnt = '0;
            binned_cnt = '0;
            peak_bin = '0;
            awaited_q.delete();
            o_pending <= 0;
        end else begin
            moved = 0;
            if (i_out_valid && i_out_ready) begin
                got = '{i_bin_index, i_in_range, i_error, i_sent_total, i_received_total,
                        i_lost_total, i_outside_total, i_binned_total, i_largest_bin,
                        i_stop, i_selected_count};
                if (awaited_q.size() == 0) begin
                    report_mismatch("result transfer with no prediction waiting");
                end else begin
                    want = awaited_q.pop_front();
                    moved--;
                    check_field("bin_index", got.bin_index, want.bin_index);
                    check_field("in_range", got.in_range, want.in_range);
                    check_field("error", got.error, want.error);
                    check_field("sent_total", got.sent_total, want.sent_total);
                    check_field("received_total", got.received_total, want.received_total);
                    check_field("lost_total", got.lost_total, want.lost_total);
                    check_field("outside_total", got.outside_total, want.outside_total);
                    check_field("binned_total", got.binned_total, want.binned_total);
                    check_field("largest_bin", got.largest_bin, want.largest_bin);
                    check_field("stop", got.stop, want.stop);
                    check_field("selected_count", got.selected_count, want.selected_count);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RANGE_BEGIN:  range_lo = i_cfg_data[RANGE_W-1:0];
                    CFG_RANGE_END:    range_hi = i_cfg_data[RANGE_W-1:0];
                    CFG_BIN_COUNT:    bins_reg = i_cfg_data[BCOUNT_W-1:0];
                    CFG_REPEAT_LIMIT: stop_limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_q.push_back(tally_event(i_mode, i_timestamp, i_bin_select));
                moved++;
            end
            o_pending <= o_pending + moved;
        end
    end

endmodule

@@ dv/latency_histogram_tb.sv @@
// latency histogram testbench top: clock, reset, event and register stimulus, verdict
module latency_histogram_tb;
    import lh_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_SETUPS    = 7;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    t_mode                   i_mode = MODE_NOP;
    logic [TS_W-1:0]         i_timestamp = '0;
    logic [SEL_W-1:0]        i_bin_select = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_bin_index;
    logic                    o_in_range;
    logic                    o_error;
    logic [OUT_W-1:0]        o_sent_total;
    logic [OUT_W-1:0]        o_received_total;
    logic [OUT_W-1:0]        o_lost_total;
    logic [OUT_W-1:0]        o_outside_total;
    logic [OUT_W-1:0]        o_binned_total;
    logic [OUT_W-2:0]        o_largest_bin;
    logic                    o_stop;
    logic [OUT_W-1:0]        o_selected_count;
    logic                    i_cfg_we = 1'b0;
    t_cfg_idx                i_cfg_index = CFG_RANGE_BEGIN;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    int fail_count;
    int pending_count;
    bit no_idle = 1'b0;

    longint cfg_lo = 0;
    longint cfg_hi = 16;
    int     cfg_bins = 16;

    logic [RANGE_W-1:0]  setup_lo    [N_SETUPS] = '{40'd5000, 40'd0, 40'd1000, 40'd300,
                                                   40'hFF_FFFF_FFFF, 40'd20, 40'd0};
    logic [RANGE_W-1:0]  setup_hi    [N_SETUPS] = '{40'd5100, 40'hFF_FFFF_FFFF, 40'd1000,
                                                   40'd200, 40'd0, 40'd52, 40'd1};
    logic [BCOUNT_W-1:0] setup_bins  [N_SETUPS] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd33,
                                                   7'd64, 7'd7};
    logic [LIMIT_W-1:0]  setup_limit [N_SETUPS] = '{32'd40, 32'd1, 32'd0, 32'hFFFF_FFFF,
                                                   32'd2, 32'd500, 32'd100};

    latency_histogram u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_timestamp      (i_timestamp),
        .i_bin_select     (i_bin_select),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_bin_index      (o_bin_index),
        .o_in_range       (o_in_range),
        .o_error          (o_error),
        .o_sent_total     (o_sent_total),
        .o_received_total (o_received_total),
        .o_lost_total     (o_lost_total),
        .o_outside_total  (o_outside_total),
        .o_binned_total   (o_binned_total),
        .o_largest_bin    (o_largest_bin),
        .o_stop           (o_stop),
        .o_selected_count (o_selected_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    latency_histogram_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_timestamp      (i_timestamp),
        .i_bin_select     (i_bin_select),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_bin_index      (o_bin_index),
        .i_in_range       (o_in_range),
        .i_error          (o_error),
        .i_sent_total     (o_sent_total),
        .i_received_total (o_received_total),
        .i_lost_total     (o_lost_total),
        .i_outside_total  (o_outside_total),
        .i_binned_total   (o_binned_total),
        .i_largest_bin    (o_largest_bin),
        .i_stop           (o_stop),
        .i_selected_count (o_selected_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic offer(t_mode m, logic [TS_W-1:0] ts, logic [SEL_W-1:0] sel);
        int gap;
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_timestamp <= ts;
        i_bin_select <= sel;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi,
                               logic [BCOUNT_W-1:0] nb, logic [LIMIT_W-1:0] lim);
        settle();
        write_reg(CFG_RANGE_BEGIN, CFG_W'(lo));
        write_reg(CFG_RANGE_END, CFG_W'(hi));
        write_reg(CFG_BIN_COUNT, CFG_W'(nb));
        write_reg(CFG_REPEAT_LIMIT, CFG_W'(lim));
        cfg_lo = longint'(lo);
        cfg_hi = longint'(hi);
        cfg_bins = (nb == 0) ? DEFAULT_BINS : (int'(nb) > MAX_BINS) ? MAX_BINS : int'(nb);
    endtask

    // latency around the binned window, with some non-positive and some far out
    function automatic longint latency_pick();
        longint span;
        longint e;
        if (cfg_hi > cfg_lo) span = cfg_hi - cfg_lo;
        else if (cfg_hi == cfg_lo) span = 64;
        else span = DEFAULT_BINS;
        span = span * NS_PER_US;
        if (span > (longint'(1) << 45)) span = longint'(1) << 45;
        case ($urandom_range(0, 9))
            0: e = -longint'($urandom_range(0, 3));
            1: e = cfg_lo - longint'($urandom_range(1, 3000));
            2: e = longint'({$urandom, $urandom} >> 18);
            default: e = cfg_lo + longint'({$urandom, $urandom} % (span + span / 8 + 1));
        endcase
        return e;
    endfunction

    task automatic run_traffic(int count);
        int              done;
        int              n;
        logic [TS_W-1:0] ts0;
        logic [SEL_W-1:0] sel;
        done = 0;
        while (done < count) begin
            no_idle = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 3) == 0) begin
                offer(t_mode'($urandom_range(0, 3)), TS_W'({$urandom, $urandom}),
                      SEL_W'($urandom));
                done++;
            end else begin
                ts0 = TS_W'({$urandom, $urandom} >> 17);
                offer(MODE_SEND, ts0, SEL_W'($urandom));
                n = $urandom_range(1, 4);
                repeat (n) offer(MODE_RECV, ts0 + TS_W'(latency_pick()), SEL_W'($urandom));
                done += n + 1;
                if ($urandom_range(0, 2) == 0) begin
                    sel = ($urandom_range(0, 2) == 0) ? SEL_W'($urandom)
                                                      : SEL_W'($urandom_range(0, cfg_bins - 1));
                    offer(MODE_READ, TS_W'({$urandom, $urandom}), sel);
                    done++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        offer(MODE_READ, '0, '0);
        offer(MODE_READ, '1, '1);
        offer(MODE_RECV, '0, '0);
        offer(MODE_SEND, TS_W'(1000), '0);
        offer(MODE_RECV, TS_W'(1000), '0);
        offer(MODE_RECV, TS_W'(999), '0);
        offer(MODE_RECV, TS_W'(1001), '0);
        offer(MODE_RECV, TS_W'(16999), '0);
        offer(MODE_RECV, TS_W'(17000), '0);
        offer(MODE_RECV, '1, '0);
        offer(MODE_NOP, '1, '1);
        offer(MODE_READ, '0, SEL_W'(0));
        offer(MODE_READ, '0, SEL_W'(15));
        offer(MODE_SEND, '1, '0);
        offer(MODE_RECV, '0, '0);
        offer(MODE_SEND, '0, '0);
        offer(MODE_RECV, TS_W'(1), '0);
        offer(MODE_READ, '0, SEL_W'(0));
        run_traffic(40);
        for (k = 0; k < N_SETUPS; k++) begin
            apply_setup(setup_lo[k], setup_hi[k], setup_bins[k], setup_limit[k]);
            run_traffic(70);
        end
        settle();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // long hold-off so the block fills and stalls its input
            if (taken == 100 || taken == 350) gap = HOLD_CYCLES;
            else gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
rtl/core/lh_pkg.sv
rtl/core/latency_histogram.sv
rtl/core/lh_check.sv
dv/latency_histogram_checker.sv
dv/latency_histogram_tb.sv
